### rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types for the sliding window median block
// Sample type and the status bundle that the sequencer hands to the top level.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SampleW = 32;
  localparam int CfgW    = 6;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [CfgW-1:0]           cfg_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic busy;  // a beat is being merged
    logic done;  // pass finished this cycle
    logic hit;   // pass finished with a full window
  } swm_stat_t;

endpackage

### rtl/swm_bank.sv
// ----------------------------------------------------------------------------
// swm_bank: one bank of window storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module swm_bank #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int W     = 37
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/swm_seq.sv
// ----------------------------------------------------------------------------
// swm_seq: merge sequencer for the sorted window
// Walks the sorted entries of one bank, ages and drops them, slots the new
// sample in with one shared signed compare, and writes the other bank.
// ----------------------------------------------------------------------------
module swm_seq #(
  parameter int WINDOW_MAX = 32,
  parameter int AW         = 5,
  parameter int CW         = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  swm_pkg::sample_t    sample,
  input  logic                clear,
  input  logic [CW-1:0]       eff_w,
  input  logic                ack,
  output swm_pkg::swm_stat_t  stat,
  output swm_pkg::sample_t    median
);
  import swm_pkg::*;

  localparam int EntW = SampleW + AW;
  localparam int KW   = (CW > AW + 1) ? CW : AW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic          ins_r, ins_nxt;
  logic          sel_r, sel_nxt;
  sample_t       samp_r, samp_nxt;
  sample_t       med_r, med_nxt;

  logic            we;
  logic [EntW-1:0] wdata;
  logic            re;
  logic [EntW-1:0] rdata0, rdata1, rdata;
  sample_t         ent_val;
  logic [AW-1:0]   ent_age;
  logic [AW:0]     age1;
  logic            keep;
  logic            gt;
  logic [CW-1:0]   mid;
  logic            full;

  // two banks, read one and write the other
  swm_bank #(.DEPTH(WINDOW_MAX), .AW(AW), .W(EntW)) u_bank0 (
    .clk(clk), .we(we && sel_r), .waddr(wr_idx_r[AW-1:0]), .wdata(wdata),
    .re(re && !sel_r), .raddr(rd_idx_r[AW-1:0]), .rdata(rdata0)
  );
  swm_bank #(.DEPTH(WINDOW_MAX), .AW(AW), .W(EntW)) u_bank1 (
    .clk(clk), .we(we && !sel_r), .waddr(wr_idx_r[AW-1:0]), .wdata(wdata),
    .re(re && sel_r), .raddr(rd_idx_r[AW-1:0]), .rdata(rdata1)
  );

  assign rdata   = sel_r ? rdata1 : rdata0;
  assign ent_val = sample_t'(rdata[EntW-1:AW]);
  assign ent_age = rdata[AW-1:0];
  assign age1    = {1'b0, ent_age} + {{AW{1'b0}}, 1'b1};
  assign keep    = KW'(age1) < KW'(w_r);
  // shared compare unit
  assign gt      = ent_val > samp_r;
  assign mid     = (w_r - {{(CW-1){1'b0}}, 1'b1}) >> 1;
  assign full    = (w_r != '0) && (wr_idx_r == w_r);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    w_nxt      = w_r;
    ins_nxt    = ins_r;
    sel_nxt    = sel_r;
    samp_nxt   = samp_r;
    med_nxt    = med_r;
    we         = 1'b0;
    wdata      = {samp_r, {AW{1'b0}}};
    re         = 1'b0;
    stat       = '{busy: 1'b1, done: 1'b0, hit: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        stat.busy = 1'b0;
        if (go) begin
          samp_nxt   = sample;
          w_nxt      = eff_w;
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          ins_nxt    = 1'b0;
          if (clear) begin
            fill_nxt = '0;
          end
          state_nxt = (eff_w == '0) ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        if (rd_idx_r < fill_r) begin
          re        = 1'b1;
          state_nxt = S_EV;
        end else begin
          if (!ins_r) begin
            we         = 1'b1;
            ins_nxt    = 1'b1;
            wr_idx_nxt = wr_idx_r + {{(CW-1){1'b0}}, 1'b1};
            if (wr_idx_r == mid) begin
              med_nxt = samp_r;
            end
          end
          state_nxt = S_FIN;
        end
      end
      S_EV: begin
        if (keep && !ins_r && gt) begin
          // sample goes ahead of this entry; revisit the entry next cycle
          we         = 1'b1;
          ins_nxt    = 1'b1;
          wr_idx_nxt = wr_idx_r + {{(CW-1){1'b0}}, 1'b1};
          if (wr_idx_r == mid) begin
            med_nxt = samp_r;
          end
        end else if (keep) begin
          we         = 1'b1;
          wdata      = {ent_val, age1[AW-1:0]};
          wr_idx_nxt = wr_idx_r + {{(CW-1){1'b0}}, 1'b1};
          rd_idx_nxt = rd_idx_r + {{(CW-1){1'b0}}, 1'b1};
          if (wr_idx_r == mid) begin
            med_nxt = ent_val;
          end
          state_nxt = S_RD;
        end else begin
          // drop an expired entry
          rd_idx_nxt = rd_idx_r + {{(CW-1){1'b0}}, 1'b1};
          state_nxt  = S_RD;
        end
      end
      S_FIN: begin
        if (!full || ack) begin
          stat.done = 1'b1;
          stat.hit  = full;
          fill_nxt  = wr_idx_r;
          sel_nxt   = !sel_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      sel_r   <= 1'b0;
      ins_r   <= 1'b0;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      sel_r    <= sel_nxt;
      ins_r    <= ins_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    samp_r <= samp_nxt;
    med_r  <= med_nxt;
  end

  assign median = med_r;

  // an entry is evaluated only if it lies below the fill level
  a_ev_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV) |-> (rd_idx_r < fill_r))
    else $error("swm_seq: evaluating entry beyond fill level");

  // writes never run ahead of reads by more than the inserted sample
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wr_idx_r} <= ({1'b0, rd_idx_r} + {{CW{1'b0}}, ins_r})))
    else $error("swm_seq: write index overtook read index");

  // a pass with a nonzero window always places the sample
  a_fin_inserted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (ins_r || (w_r == '0)))
    else $error("swm_seq: pass finished without inserting the sample");

endmodule

### rtl/sliding_window_median_top.sv
// Pass: an accepted beat starts a merge pass that reads and evaluates the entries
//   held before it; a kept entry is seen again when the sample goes ahead of it.
//   A pass with a full window holds its finish while the result side stalls.
// Throughput: one beat per merge pass (one shared signed compare); the next beat
//   is taken only once the previous pass has finished, also for a zero window.
// Reset: window_size returns to 3 and the window empties; memory is not cleared.
// ----------------------------------------------------------------------------
// sliding_window_median_top: running lower median filter
// Keeps the last min(window_size,WINDOW_MAX) samples sorted; gives the lower median.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
  parameter int WINDOW_MAX = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  swm_pkg::sample_t  in_sample,
  input  logic              in_start_req,
  output logic              out_valid,
  input  logic              out_stall,
  output swm_pkg::sample_t  out_median,
  input  logic              cfg_wr_en,
  input  swm_pkg::cfg_t     cfg_wr_data
);
  import swm_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int EW = (CW > CfgW) ? CW : CfgW;

  cfg_t          window_size_r;
  logic [CW-1:0] eff_w;
  logic          go;
  logic          ack;
  swm_stat_t     stat;
  sample_t       median;
  logic          out_valid_r;
  sample_t       out_median_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CfgW'(3);
    end else if (cfg_wr_en) begin
      window_size_r <= cfg_wr_data;
    end
  end

  // clamp the window to the storage depth
  assign eff_w = (EW'(window_size_r) > EW'(WINDOW_MAX)) ? CW'(WINDOW_MAX)
                                                       : CW'(window_size_r);

  assign in_stall = stat.busy;
  assign go       = in_valid && !stat.busy;
  assign ack      = !out_valid_r || !out_stall;

  swm_seq #(.WINDOW_MAX(WINDOW_MAX), .AW(AW), .CW(CW)) u_seq (
    .clk(clk), .rst_n(rst_n), .go(go), .sample(in_sample),
    .clear(in_start_req), .eff_w(eff_w), .ack(ack), .stat(stat), .median(median)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done && stat.hit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && stat.hit) begin
      out_median_r <= median;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.done && stat.hit) |-> (!out_valid_r || !out_stall))
    else $error("top: result overwrote a waiting beat");

  // an accepted input beat starts a pass, so the sequencer turns busy
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> stat.busy)
    else $error("top: accepted beat did not start a pass");

  // pass completion never coincides with a new beat
  a_done_no_go: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> !go)
    else $error("top: beat accepted during pass completion");

endmodule
